### hw/rtl/hril_pkg.sv
// shared constants and codes for the hierarchical range index lookup
// no dependencies
package hril_pkg;
  localparam int BOOK_DEPTH_DEF    = 128;
  localparam int CHAPTER_DEPTH_DEF = 2048;
  localparam int RANGE_DEPTH_DEF   = 8192;

  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_BOOK   = 3'd1;
  localparam logic [2:0] FUNC_CHAP   = 3'd2;
  localparam logic [2:0] FUNC_RANGE  = 3'd3;
  localparam logic [2:0] FUNC_LOOKUP = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_BOOK  = 3'd1;
  localparam logic [2:0] ST_NO_CHAP  = 3'd2;
  localparam logic [2:0] ST_NO_VERSE = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
endpackage

### hw/rtl/hierarchical_range_index_lookup.sv
// top level of the hierarchical range index lookup: three tables and a walk sequencer
// depends on hril_pkg
//
// One command is taken when start is high and busy is low. Clear, the appends and
// unknown codes go from idle straight to the done state. A lookup walks the book
// table (up to the book count), then the book's chapter span, then the chapter's range
// span, each record in a request state and then a compare state through a single
// shared compare stage; each table read is registered. No new command is taken until
// the lookup is through. The result shows on the output ports with done high for
// exactly one cycle; the receiver cannot stall it, so it must take the transfer in
// that cycle. Table contents are not cleared: counts bound every read, so no
// clearing pass is needed after reset.
module hierarchical_range_index_lookup #(
  parameter int BOOK_DEPTH    = hril_pkg::BOOK_DEPTH_DEF,
  parameter int CHAPTER_DEPTH = hril_pkg::CHAPTER_DEPTH_DEF,
  parameter int RANGE_DEPTH   = hril_pkg::RANGE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [7:0]  book_id,
  input  logic [7:0]  chapter_id,
  input  logic [7:0]  child_count,
  input  logic [7:0]  verse_num,
  input  logic [7:0]  verse_last,
  input  logic [31:0] entry_tag,
  output logic        done,
  output logic [2:0]  status,
  output logic [6:0]  book_slot,
  output logic [10:0] chapter_slot,
  output logic [12:0] range_slot,
  output logic [31:0] found_tag
);
  import hril_pkg::*;

  localparam int BA = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CA = (CHAPTER_DEPTH > 1) ? $clog2(CHAPTER_DEPTH) : 1;
  localparam int RA = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
  localparam int BC = $clog2(BOOK_DEPTH + 1);
  localparam int CC = $clog2(CHAPTER_DEPTH + 1);
  localparam int RC = $clog2(RANGE_DEPTH + 1);

  // book record: id, count, first chapter slot
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  count;
    logic [CC-1:0] first;
  } book_rec_t;
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  count;
    logic [RC-1:0] first;
  } chap_rec_t;
  typedef struct packed {
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [31:0] tag;
  } range_rec_t;

  book_rec_t  book_mem  [BOOK_DEPTH];
  chap_rec_t  chap_mem  [CHAPTER_DEPTH];
  range_rec_t range_mem [RANGE_DEPTH];

  book_rec_t  book_rd;
  chap_rec_t  chap_rd;
  range_rec_t range_rd;

  logic [BC-1:0] books_used;
  logic [CC-1:0] chapters_used;
  logic [RC-1:0] ranges_used;

  typedef enum logic [2:0] {
    S_IDLE, S_BREQ, S_BCMP, S_CREQ, S_CCMP, S_RREQ, S_RCMP, S_DONE
  } state_t;
  state_t state;

  // command latched at the transfer
  logic [7:0] req_book, req_chap, req_verse;

  // walk position: absolute slot and steps left in the span
  logic [16:0] idx;
  logic [8:0]  left;

  // memory address, taken from the walk position
  logic [16:0] rd_addr;
  assign rd_addr = idx;

  // shared compare stage: in-bounds and key or verse-range match for the record just read
  logic hit_now;
  logic in_bounds;
  always_comb begin
    in_bounds = 1'b0;
    hit_now   = 1'b0;
    case (state)
      S_BCMP: begin
        in_bounds = ({{(17-BC){1'b0}}, books_used} > idx);
        hit_now   = in_bounds && (book_rd.id == req_book);
      end
      S_CCMP: begin
        in_bounds = ({{(17-CC){1'b0}}, chapters_used} > idx);
        hit_now   = in_bounds && (chap_rd.id == req_chap);
      end
      S_RCMP: begin
        in_bounds = ({{(17-RC){1'b0}}, ranges_used} > idx);
        hit_now   = in_bounds && (range_rd.lo <= req_verse) && (req_verse <= range_rd.hi);
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (start && !busy && func == FUNC_BOOK && books_used < BC'(BOOK_DEPTH))
      book_mem[books_used[BA-1:0]] <= '{book_id, child_count, chapters_used};
    if (start && !busy && func == FUNC_CHAP && chapters_used < CC'(CHAPTER_DEPTH))
      chap_mem[chapters_used[CA-1:0]] <= '{chapter_id, child_count, ranges_used};
    if (start && !busy && func == FUNC_RANGE && ranges_used < RC'(RANGE_DEPTH))
      range_mem[ranges_used[RA-1:0]] <= '{verse_num, verse_last, entry_tag};
    book_rd  <= book_mem[rd_addr[BA-1:0]];
    chap_rd  <= chap_mem[rd_addr[CA-1:0]];
    range_rd <= range_mem[rd_addr[RA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      books_used    <= '0;
      chapters_used <= '0;
      ranges_used   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            status       <= ST_OK;
            book_slot    <= '0;
            chapter_slot <= '0;
            range_slot   <= '0;
            found_tag    <= '0;
            req_book     <= book_id;
            req_chap     <= chapter_id;
            req_verse    <= verse_num;
            state        <= S_DONE;
            case (func)
              FUNC_CLEAR: begin
                books_used    <= '0;
                chapters_used <= '0;
                ranges_used   <= '0;
              end
              FUNC_BOOK: begin
                if (books_used < BC'(BOOK_DEPTH)) begin
                  book_slot  <= 7'(books_used);
                  books_used <= books_used + 1'b1;
                end else status <= ST_FULL;
              end
              FUNC_CHAP: begin
                if (chapters_used < CC'(CHAPTER_DEPTH)) begin
                  chapter_slot  <= 11'(chapters_used);
                  chapters_used <= chapters_used + 1'b1;
                end else status <= ST_FULL;
              end
              FUNC_RANGE: begin
                if (ranges_used < RC'(RANGE_DEPTH)) begin
                  range_slot  <= 13'(ranges_used);
                  ranges_used <= ranges_used + 1'b1;
                end else status <= ST_FULL;
              end
              FUNC_LOOKUP: begin
                idx   <= '0;
                state <= S_BREQ;
              end
              default: ;
            endcase
          end
        end
        S_BREQ: begin
          // book walk ends at the count
          if (idx >= {{(17-BC){1'b0}}, books_used}) begin
            status <= ST_NO_BOOK;
            state  <= S_DONE;
          end else state <= S_BCMP;
        end
        S_BCMP: begin
          if (hit_now) begin
            book_slot <= 7'(idx);
            idx       <= 17'(book_rd.first);
            left      <= {1'b0, book_rd.count};
            state     <= S_CREQ;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_BREQ;
          end
        end
        S_CREQ: begin
          if (left == '0) begin
            status <= ST_NO_CHAP;
            state  <= S_DONE;
          end else state <= S_CCMP;
        end
        S_CCMP: begin
          if (hit_now) begin
            chapter_slot <= 11'(idx);
            idx          <= 17'(chap_rd.first);
            left         <= (req_verse == 8'd0) ? 9'd0 : {1'b0, chap_rd.count};
            state        <= S_RREQ;
          end else begin
            idx   <= idx + 1'b1;
            left  <= left - 1'b1;
            state <= S_CREQ;
          end
        end
        S_RREQ: begin
          if (left == '0) begin
            status <= ST_NO_VERSE;
            state  <= S_DONE;
          end else state <= S_RCMP;
        end
        S_RCMP: begin
          if (hit_now) begin
            range_slot <= 13'(idx);
            found_tag  <= range_rd.tag;
            state      <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            left  <= left - 1'b1;
            state <= S_RREQ;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
